>>> sv/cpu8eu_pkg.sv
// Package for the 8-bit execute unit: operation kinds, register state type
// and shared helpers. No dependencies.
package cpu8eu_pkg;

  localparam int unsigned KindWidth = 6;

  typedef enum logic [KindWidth-1:0] {
    K_LDA = 6'd0,  K_LDX = 6'd1,  K_LDY = 6'd2,  K_TAX = 6'd3,  K_TAY = 6'd4,
    K_TXA = 6'd5,  K_TYA = 6'd6,  K_TSX = 6'd7,  K_TXS = 6'd8,  K_LAX = 6'd9,
    K_INX = 6'd10, K_INY = 6'd11, K_DEX = 6'd12, K_DEY = 6'd13,
    K_ADC = 6'd14, K_SBC = 6'd15, K_AND = 6'd16, K_ORA = 6'd17, K_EOR = 6'd18,
    K_CMP = 6'd19, K_CPX = 6'd20, K_CPY = 6'd21, K_BIT = 6'd22,
    K_ASL_M = 6'd23, K_LSR_M = 6'd24, K_ROL_M = 6'd25, K_ROR_M = 6'd26,
    K_ASL_A = 6'd27, K_LSR_A = 6'd28, K_ROL_A = 6'd29, K_ROR_A = 6'd30,
    K_INC = 6'd31, K_DEC = 6'd32,
    K_CLC = 6'd33, K_SEC = 6'd34, K_CLI = 6'd35, K_SEI = 6'd36, K_CLV = 6'd37,
    K_CLD = 6'd38, K_SED = 6'd39,
    K_SAX = 6'd40, K_LXA = 6'd41, K_SBX = 6'd42, K_DCP = 6'd43, K_ISB = 6'd44,
    K_SLO = 6'd45, K_RLA = 6'd46, K_SRE = 6'd47, K_RRA = 6'd48,
    K_ALR = 6'd49, K_ANC = 6'd50, K_ARR = 6'd51
  } kind_e;

  typedef struct packed {
    logic n;
    logic v;
    logic d;
    logic i;
    logic z;
    logic c;
  } flags_t;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] sp;
    flags_t     f;
  } cpu_state_t;

  typedef struct packed {
    logic [7:0] r;
    logic       c;
    logic       v;
  } add_t;

  function automatic add_t add8(logic [7:0] a, logic [7:0] b, logic cin);
    logic [8:0] s;
    add_t       o;
    s   = {1'b0, a} + {1'b0, b} + {8'b0, cin};
    o.r = s[7:0];
    o.c = s[8];
    o.v = (a[7] ~^ b[7]) & (a[7] ^ s[7]);
    return o;
  endfunction

  function automatic logic [7:0] pack_status(flags_t f);
    return {f.n, f.v, 1'b1, 1'b0, f.d, f.i, f.z, f.c};
  endfunction

endpackage

>>> sv/cpu8eu_alu.sv
// Combinational execute logic: decodes one operation kind and computes the
// next register state and the memory write-back. Depends on cpu8eu_pkg.
module cpu8eu_alu (
  input  cpu8eu_pkg::cpu_state_t st_i,
  input  logic [cpu8eu_pkg::KindWidth-1:0] kind_i,
  input  logic [7:0]             operand_i,
  output cpu8eu_pkg::cpu_state_t st_o,
  output logic [7:0]             wdata_o,
  output logic                   wen_o
);

  always_comb begin
    cpu8eu_pkg::cpu_state_t nx;
    cpu8eu_pkg::add_t ad;
    logic [7:0] m;
    logic [7:0] t;
    logic [7:0] r;
    logic       ci;
    logic       upd_nz;
    nx      = st_i;
    m       = operand_i;
    ci      = st_i.f.c;
    ad      = cpu8eu_pkg::add8(st_i.a, m, ci);
    t       = 8'h00;
    r       = 8'h00;
    upd_nz  = 1'b0;
    wdata_o = 8'h00;
    wen_o   = 1'b0;
    unique case (cpu8eu_pkg::kind_e'(kind_i))
      cpu8eu_pkg::K_LDA: begin nx.a = m; r = m; upd_nz = 1'b1; end
      cpu8eu_pkg::K_LDX: begin nx.x = m; r = m; upd_nz = 1'b1; end
      cpu8eu_pkg::K_LDY: begin nx.y = m; r = m; upd_nz = 1'b1; end
      cpu8eu_pkg::K_TAX: begin nx.x = st_i.a; r = st_i.a; upd_nz = 1'b1; end
      cpu8eu_pkg::K_TAY: begin nx.y = st_i.a; r = st_i.a; upd_nz = 1'b1; end
      cpu8eu_pkg::K_TXA: begin nx.a = st_i.x; r = st_i.x; upd_nz = 1'b1; end
      cpu8eu_pkg::K_TYA: begin nx.a = st_i.y; r = st_i.y; upd_nz = 1'b1; end
      cpu8eu_pkg::K_TSX: begin nx.x = st_i.sp; r = st_i.sp; upd_nz = 1'b1; end
      cpu8eu_pkg::K_TXS: nx.sp = st_i.x;
      cpu8eu_pkg::K_LAX, cpu8eu_pkg::K_LXA: begin
        nx.a = m; nx.x = m; r = m; upd_nz = 1'b1;
      end
      cpu8eu_pkg::K_INX: begin r = st_i.x + 8'd1; nx.x = r; upd_nz = 1'b1; end
      cpu8eu_pkg::K_INY: begin r = st_i.y + 8'd1; nx.y = r; upd_nz = 1'b1; end
      cpu8eu_pkg::K_DEX: begin r = st_i.x - 8'd1; nx.x = r; upd_nz = 1'b1; end
      cpu8eu_pkg::K_DEY: begin r = st_i.y - 8'd1; nx.y = r; upd_nz = 1'b1; end
      cpu8eu_pkg::K_ADC, cpu8eu_pkg::K_SBC: begin
        ad = cpu8eu_pkg::add8(st_i.a, (kind_i == cpu8eu_pkg::K_SBC) ? ~m : m, ci);
        nx.a = ad.r; nx.f.c = ad.c; nx.f.v = ad.v; r = ad.r; upd_nz = 1'b1;
      end
      cpu8eu_pkg::K_AND: begin r = st_i.a & m; nx.a = r; upd_nz = 1'b1; end
      cpu8eu_pkg::K_ORA: begin r = st_i.a | m; nx.a = r; upd_nz = 1'b1; end
      cpu8eu_pkg::K_EOR: begin r = st_i.a ^ m; nx.a = r; upd_nz = 1'b1; end
      cpu8eu_pkg::K_CMP, cpu8eu_pkg::K_CPX, cpu8eu_pkg::K_CPY: begin
        if (kind_i == cpu8eu_pkg::K_CMP)      t = st_i.a;
        else if (kind_i == cpu8eu_pkg::K_CPX) t = st_i.x;
        else                                  t = st_i.y;
        ad = cpu8eu_pkg::add8(t, ~m, 1'b1);
        nx.f.c = ad.c; r = ad.r; upd_nz = 1'b1;
      end
      cpu8eu_pkg::K_BIT: begin
        nx.f.n = m[7]; nx.f.v = m[6]; nx.f.z = ((st_i.a & m) == 8'h00);
      end
      cpu8eu_pkg::K_ASL_M: begin
        r = {m[6:0], 1'b0}; nx.f.c = m[7]; upd_nz = 1'b1; wdata_o = r; wen_o = 1'b1;
      end
      cpu8eu_pkg::K_LSR_M: begin
        r = {1'b0, m[7:1]}; nx.f.c = m[0]; upd_nz = 1'b1; wdata_o = r; wen_o = 1'b1;
      end
      cpu8eu_pkg::K_ROL_M: begin
        r = {m[6:0], ci}; nx.f.c = m[7]; upd_nz = 1'b1; wdata_o = r; wen_o = 1'b1;
      end
      cpu8eu_pkg::K_ROR_M: begin
        r = {ci, m[7:1]}; nx.f.c = m[0]; upd_nz = 1'b1; wdata_o = r; wen_o = 1'b1;
      end
      cpu8eu_pkg::K_ASL_A: begin
        r = {st_i.a[6:0], 1'b0}; nx.f.c = st_i.a[7]; nx.a = r; upd_nz = 1'b1;
      end
      cpu8eu_pkg::K_LSR_A: begin
        r = {1'b0, st_i.a[7:1]}; nx.f.c = st_i.a[0]; nx.a = r; upd_nz = 1'b1;
      end
      cpu8eu_pkg::K_ROL_A: begin
        r = {st_i.a[6:0], ci}; nx.f.c = st_i.a[7]; nx.a = r; upd_nz = 1'b1;
      end
      cpu8eu_pkg::K_ROR_A: begin
        r = {ci, st_i.a[7:1]}; nx.f.c = st_i.a[0]; nx.a = r; upd_nz = 1'b1;
      end
      cpu8eu_pkg::K_INC: begin
        r = m + 8'd1; upd_nz = 1'b1; wdata_o = r; wen_o = 1'b1;
      end
      cpu8eu_pkg::K_DEC: begin
        r = m - 8'd1; upd_nz = 1'b1; wdata_o = r; wen_o = 1'b1;
      end
      cpu8eu_pkg::K_CLC: nx.f.c = 1'b0;
      cpu8eu_pkg::K_SEC: nx.f.c = 1'b1;
      cpu8eu_pkg::K_CLI: nx.f.i = 1'b0;
      cpu8eu_pkg::K_SEI: nx.f.i = 1'b1;
      cpu8eu_pkg::K_CLV: nx.f.v = 1'b0;
      cpu8eu_pkg::K_CLD: nx.f.d = 1'b0;
      cpu8eu_pkg::K_SED: nx.f.d = 1'b1;
      cpu8eu_pkg::K_SAX: begin wdata_o = st_i.a & st_i.x; wen_o = 1'b1; end
      cpu8eu_pkg::K_SBX: begin
        ad = cpu8eu_pkg::add8(st_i.a & st_i.x, ~m, 1'b1);
        nx.x = ad.r; nx.f.c = ad.c; r = ad.r; upd_nz = 1'b1;
      end
      cpu8eu_pkg::K_DCP: begin
        t = m - 8'd1; wdata_o = t; wen_o = 1'b1;
        ad = cpu8eu_pkg::add8(st_i.a, ~t, 1'b1);
        nx.f.c = ad.c; r = ad.r; upd_nz = 1'b1;
      end
      cpu8eu_pkg::K_ISB: begin
        t = m + 8'd1; wdata_o = t; wen_o = 1'b1;
        ad = cpu8eu_pkg::add8(st_i.a, ~t, ci);
        nx.a = ad.r; nx.f.c = ad.c; nx.f.v = ad.v; r = ad.r; upd_nz = 1'b1;
      end
      cpu8eu_pkg::K_SLO: begin
        t = {m[6:0], 1'b0}; nx.f.c = m[7]; wdata_o = t; wen_o = 1'b1;
        r = st_i.a | t; nx.a = r; upd_nz = 1'b1;
      end
      cpu8eu_pkg::K_RLA: begin
        t = {m[6:0], ci}; nx.f.c = m[7]; wdata_o = t; wen_o = 1'b1;
        r = st_i.a & t; nx.a = r; upd_nz = 1'b1;
      end
      cpu8eu_pkg::K_SRE: begin
        t = {1'b0, m[7:1]}; nx.f.c = m[0]; wdata_o = t; wen_o = 1'b1;
        r = st_i.a ^ t; nx.a = r; upd_nz = 1'b1;
      end
      cpu8eu_pkg::K_RRA: begin
        t = {ci, m[7:1]}; wdata_o = t; wen_o = 1'b1;
        ad = cpu8eu_pkg::add8(st_i.a, t, m[0]);
        nx.a = ad.r; nx.f.c = ad.c; nx.f.v = ad.v; r = ad.r; upd_nz = 1'b1;
      end
      cpu8eu_pkg::K_ALR: begin
        t = st_i.a & m; nx.f.c = t[0];
        r = {1'b0, t[7:1]}; nx.a = r; upd_nz = 1'b1;
      end
      cpu8eu_pkg::K_ANC: begin
        r = st_i.a & m; nx.a = r; nx.f.c = r[7]; upd_nz = 1'b1;
      end
      cpu8eu_pkg::K_ARR: begin
        t = st_i.a & m;
        r = {ci, t[7:1]}; nx.a = r; upd_nz = 1'b1;
        nx.f.c = r[6]; nx.f.v = r[6] ^ r[5];
      end
      default: ;
    endcase
    if (upd_nz) begin
      nx.f.z = (r == 8'h00);
      nx.f.n = r[7];
    end
    st_o = nx;
  end

endmodule

>>> sv/cpu8_execute_unit.sv
// Top level of the 8-bit execute unit: input register, architectural state
// and result register around cpu8eu_alu. Depends on cpu8eu_pkg, cpu8eu_alu.
//
//  channel | handshake              | payload
//  --------+------------------------+-------------------------------------------
//  in      | in_valid_i, in_ready_o | kind_i, operand_i
//  out     | out_valid_o, out_ready_i | write_data_o, write_enable_o, acc_out_o,
//          |                        | index_x_out_o, index_y_out_o, status_out_o
//
// One item per cycle while out_ready_i holds; items pass the input register, then
// execute into the result register, where the A/X/Y/SP/flags update lands too.
// Reset clears A, X, Y, SP and all flags but I (status reads 0x24).
// A stalled result holds the result register; the input register still takes
// one more item, and in_ready_o drops only when both stages are full.
module cpu8_execute_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [5:0] kind_i,
  input  logic [7:0] operand_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] write_data_o,
  output logic       write_enable_o,
  output logic [7:0] acc_out_o,
  output logic [7:0] index_x_out_o,
  output logic [7:0] index_y_out_o,
  output logic [7:0] status_out_o
);

  logic                   in_valid_q;
  logic [5:0]             kind_q;
  logic [7:0]             operand_q;
  cpu8eu_pkg::cpu_state_t st_q, st_d;
  logic                   out_valid_q;
  logic [7:0]             wdata_q, wdata_d;
  logic                   wen_q, wen_d;
  logic                   advance;
  logic                   in_fire;

  assign advance    = in_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~in_valid_q | advance;
  assign in_fire    = in_valid_i & in_ready_o;

  cpu8eu_alu u_alu (
    .st_i      (st_q),
    .kind_i    (kind_q),
    .operand_i (operand_q),
    .st_o      (st_d),
    .wdata_o   (wdata_d),
    .wen_o     (wen_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= '{a: 8'h00, x: 8'h00, y: 8'h00, sp: 8'h00,
                       f: '{n: 1'b0, v: 1'b0, d: 1'b0, i: 1'b1, z: 1'b0, c: 1'b0}};
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (advance) begin
        out_valid_q <= 1'b1;
        st_q        <= st_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q    <= kind_i;
      operand_q <= operand_i;
    end
    if (advance) begin
      wdata_q <= wdata_d;
      wen_q   <= wen_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign write_data_o   = wdata_q;
  assign write_enable_o = wen_q;
  assign acc_out_o      = st_q.a;
  assign index_x_out_o  = st_q.x;
  assign index_y_out_o  = st_q.y;
  assign status_out_o   = cpu8eu_pkg::pack_status(st_q.f);

endmodule
